// File: sv/pfdf_pkg.sv
// ----------------------------------------------------------------------------
// pfdf_pkg: shared types and constants of the driving force unit
// Field widths, configuration register indexes and the CORDIC angle table.
// ----------------------------------------------------------------------------
package pfdf_pkg;

  localparam int PHI_W      = 24;
  localparam int TEMP_W     = 32;
  localparam int FORCE_W    = 32;
  localparam int ALPHA_W    = 24;
  localparam int GAMMA_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int VEC_W      = 31;
  localparam int CORDIC_W   = 34;
  localparam int ANGLE_SLOTS = 32;

  localparam logic [ALPHA_W-1:0] RESET_COUPLING = 24'd58982;
  localparam logic [GAMMA_W-1:0] RESET_GAIN     = 32'd655360;
  localparam logic [TEMP_W-1:0]  RESET_EQ_TEMP  = 32'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COUPLING = 2'd0,
    CFG_GAIN     = 2'd1,
    CFG_EQ_TEMP  = 2'd2
  } cfg_index_t;

  // Entry i is round(2^32 * atan(2^-i) / pi).
  localparam logic [31:0] ANGLE_TABLE [ANGLE_SLOTS] = '{
    32'd1073741824, 32'd633866811, 32'd334917815, 32'd170009512,
    32'd85334662,   32'd42708931,  32'd21359677,  32'd10680490,
    32'd5340327,    32'd2670173,   32'd1335088,   32'd667544,
    32'd333772,     32'd166886,    32'd83443,     32'd41722,
    32'd20861,      32'd10430,     32'd5215,      32'd2608,
    32'd1304,       32'd652,       32'd326,       32'd163,
    32'd81,         32'd41,        32'd20,        32'd10,
    32'd5,          32'd3,         32'd1,         32'd1
  };

  typedef struct packed {
    logic signed [PHI_W-1:0] phi;
    logic                    neg;
    logic                    zero;
  } side_t;

endpackage

// File: sv/pfdf_point_if.sv
// ----------------------------------------------------------------------------
// pfdf_point_if: input channel of the driving force unit
// Carries one grid point, phase value and temperature, per transfer.
// ----------------------------------------------------------------------------
interface pfdf_point_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pfdf_pkg::PHI_W-1:0]    phase_value;
  logic signed [pfdf_pkg::TEMP_W-1:0]   temperature;
  modport source (output valid, phase_value, temperature, input ready);
  modport sink (input valid, phase_value, temperature, output ready);
endinterface

// File: sv/pfdf_force_if.sv
// ----------------------------------------------------------------------------
// pfdf_force_if: output channel of the driving force unit
// Carries one driving force value per transfer.
// ----------------------------------------------------------------------------
interface pfdf_force_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pfdf_pkg::FORCE_W-1:0]  driving_force;
  modport source (output valid, driving_force, input ready);
  modport sink (input valid, driving_force, output ready);
endinterface

// File: sv/pfdf_cfg_if.sv
// ----------------------------------------------------------------------------
// pfdf_cfg_if: configuration write channel
// Carries a register index and write data per transfer.
// ----------------------------------------------------------------------------
interface pfdf_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [pfdf_pkg::CFG_IDX_W-1:0]      index;
  logic [pfdf_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/pfdf_front.sv
// ----------------------------------------------------------------------------
// pfdf_front: undercooling, gain product and CORDIC vector set-up
// Five stages: difference, split product, product sum, shift search, shift.
// ----------------------------------------------------------------------------
module pfdf_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [pfdf_pkg::PHI_W-1:0]   phase_value,
  input  logic signed [pfdf_pkg::TEMP_W-1:0]  temperature,
  input  logic [pfdf_pkg::GAMMA_W-1:0]        gain,
  input  logic signed [pfdf_pkg::TEMP_W-1:0]  eq_temp,
  output logic                                out_valid,
  output logic [pfdf_pkg::VEC_W-1:0]          x_out,
  output logic [pfdf_pkg::VEC_W-1:0]          y_out,
  output pfdf_pkg::side_t                     side_out
);

  logic signed [32:0] diff;
  logic [32:0]        diff_mag;
  logic [47:0]        prod_lo;
  logic [48:0]        prod_hi;
  logic [63:0]        prod_sum;
  logic [5:0]         shift_next;
  logic [63:0]        x_wide;

  logic v1, v2, v3, v4;
  logic signed [pfdf_pkg::PHI_W-1:0] phi1, phi2, phi3, phi4;
  logic neg1, neg2, neg3, neg4;
  logic [32:0] dmag1;
  logic [47:0] lo2;
  logic [48:0] hi2;
  logic [63:0] p3, p4;
  logic [5:0]  shift4;
  logic        zero4;

  assign diff     = 33'(eq_temp) - 33'(temperature);
  assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
  assign prod_lo  = 48'(gain) * 48'(dmag1[15:0]);
  assign prod_hi  = 49'(gain) * 49'(dmag1[32:16]);
  assign prod_sum = {hi2[47:0], 16'b0} + {16'b0, lo2};

  always_comb begin
    shift_next = 6'd3;
    for (int b = 0; b < 32; b++) begin
      if (p3[32 + b]) begin
        shift_next = 6'(b + 3);
      end
    end
  end

  assign x_wide = (64'd1 << 32) >> shift4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      phi1   <= phase_value;
      neg1   <= diff[32];
      dmag1  <= diff_mag;
      phi2   <= phi1;
      neg2   <= neg1;
      lo2    <= prod_lo;
      hi2    <= prod_hi;
      phi3   <= phi2;
      neg3   <= neg2;
      p3     <= prod_sum;
      phi4   <= phi3;
      neg4   <= neg3;
      p4     <= p3;
      shift4 <= shift_next;
      zero4  <= (p3 == 64'd0);
      x_out  <= x_wide[pfdf_pkg::VEC_W-1:0];
      y_out  <= pfdf_pkg::VEC_W'(p4 >> shift4);
      side_out.phi  <= phi4;
      side_out.neg  <= neg4;
      side_out.zero <= zero4;
    end
  end

endmodule

// File: sv/pfdf_cordic.sv
// ----------------------------------------------------------------------------
// pfdf_cordic: vectoring CORDIC pipeline
// One register stage per iteration; the angle accumulates in units of pi.
// ----------------------------------------------------------------------------
module pfdf_cordic #(
  parameter int ATAN_STAGES = 20
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic [pfdf_pkg::VEC_W-1:0]         x_in,
  input  logic [pfdf_pkg::VEC_W-1:0]         y_in,
  input  pfdf_pkg::side_t                    side_in,
  output logic                               out_valid,
  output logic signed [pfdf_pkg::CORDIC_W-1:0] z_out,
  output pfdf_pkg::side_t                    side_out
);

  localparam int W = pfdf_pkg::CORDIC_W;

  logic signed [W-1:0] xs [ATAN_STAGES+1];
  logic signed [W-1:0] ys [ATAN_STAGES+1];
  logic signed [W-1:0] zs [ATAN_STAGES+1];
  logic                vs [ATAN_STAGES+1];
  pfdf_pkg::side_t     ss [ATAN_STAGES+1];

  assign xs[0] = W'(x_in);
  assign ys[0] = W'(y_in);
  assign zs[0] = '0;
  assign vs[0] = in_valid;
  assign ss[0] = side_in;

  for (genvar i = 0; i < ATAN_STAGES; i++) begin : g_stage
    logic signed [W-1:0] dx, dy, angle;
    logic                down;

    assign dx    = ys[i] >>> (i % pfdf_pkg::ANGLE_SLOTS);
    assign dy    = xs[i] >>> (i % pfdf_pkg::ANGLE_SLOTS);
    assign angle = W'(pfdf_pkg::ANGLE_TABLE[i % pfdf_pkg::ANGLE_SLOTS]);
    assign down  = !ys[i][W-1] && (ys[i] != '0);

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[i+1] <= 1'b0;
      end else if (en) begin
        vs[i+1] <= vs[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xs[i+1] <= down ? xs[i] + dx : xs[i] - dx;
        ys[i+1] <= down ? ys[i] - dy : ys[i] + dy;
        zs[i+1] <= down ? zs[i] + angle : zs[i] - angle;
        ss[i+1] <= ss[i];
      end
    end
  end

  assign out_valid = vs[ATAN_STAGES];
  assign z_out     = zs[ATAN_STAGES];
  assign side_out  = ss[ATAN_STAGES];

endmodule

// File: sv/pfdf_back.sv
// ----------------------------------------------------------------------------
// pfdf_back: polynomial part of the driving force
// Clamps the angle, scales it by alpha, forms phi*(1-phi) and the final
// product, rounds and saturates over seven stages.
// ----------------------------------------------------------------------------
module pfdf_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic signed [pfdf_pkg::CORDIC_W-1:0]  z_in,
  input  pfdf_pkg::side_t                       side_in,
  input  logic [pfdf_pkg::ALPHA_W-1:0]          alpha,
  output logic                                  out_valid,
  output logic signed [pfdf_pkg::FORCE_W-1:0]   driving_force
);

  localparam int PW = pfdf_pkg::PHI_W;

  logic [31:0]        theta_next;
  logic [55:0]        m_prod;
  logic signed [24:0] one_minus;
  logic signed [48:0] q_prod;
  logic [28:0]        m_mag;
  logic [48:0]        q_abs;
  logic signed [30:0] s_sum;
  logic [48:0]        hi_prod;
  logic [47:0]        lo_prod;
  logic [66:0]        p_sum;
  logic [42:0]        r_mag;
  logic [31:0]        r_next;

  logic v1, v2, v3, v4, v5, v6;
  logic signed [PW-1:0] phi1, phi2, phi3;
  logic neg1, neg2;
  logic [31:0] theta1;
  logic [55:0] mp2;
  logic signed [48:0] qp2;
  logic signed [29:0] m3;
  logic [36:0] qm3, qm4;
  logic qneg3;
  logic [29:0] sm4;
  logic neg4, neg5, neg6;
  logic [48:0] hi5;
  logic [47:0] lo5;
  logic [66:0] pm6;

  always_comb begin
    if (side_in.zero || z_in[pfdf_pkg::CORDIC_W-1]) begin
      theta_next = '0;
    end else if (z_in > pfdf_pkg::CORDIC_W'(34'sd2147483648)) begin
      theta_next = 32'h8000_0000;
    end else begin
      theta_next = z_in[31:0];
    end
  end

  assign m_prod    = 56'(alpha) * 56'(theta1);
  assign one_minus = 25'sd65536 - 25'(phi1);
  assign q_prod    = 49'(phi1) * 49'(one_minus);

  assign m_mag = 29'((mp2 + 56'd134217728) >> 28);
  assign q_abs = qp2[48] ? 49'(-qp2) : 49'(qp2);

  assign s_sum = (31'(phi3) <<< 4) - 31'sd524288 + 31'(m3);

  assign hi_prod = 49'(qm4[36:18]) * 49'(sm4);
  assign lo_prod = 48'(qm4[17:0]) * 48'(sm4);

  assign p_sum = {hi5, 18'b0} + 67'(lo5);

  assign r_mag = 43'((pm6 + 67'd8388608) >> 24);

  always_comb begin
    if (neg6) begin
      r_next = (r_mag > 43'd2147483648) ? 32'h8000_0000 : 32'(-r_mag[31:0]);
    end else begin
      r_next = (r_mag > 43'd2147483647) ? 32'h7FFF_FFFF : r_mag[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      out_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      theta1 <= theta_next;
      phi1   <= side_in.phi;
      neg1   <= side_in.neg;
      mp2    <= m_prod;
      qp2    <= q_prod;
      phi2   <= phi1;
      neg2   <= neg1;
      m3     <= neg2 ? -30'(m_mag) : 30'(m_mag);
      qm3    <= 37'(q_abs >> 12) + 37'(q_abs[11]);
      qneg3  <= qp2[48];
      phi3   <= phi2;
      qm4    <= qm3;
      sm4    <= s_sum[30] ? 30'(-s_sum) : 30'(s_sum);
      neg4   <= qneg3 ^ s_sum[30];
      hi5    <= hi_prod;
      lo5    <= lo_prod;
      neg5   <= neg4;
      pm6    <= p_sum;
      neg6   <= neg5;
      driving_force <= r_next;
    end
  end

endmodule

// File: sv/phase_field_driving_force_unit.sv
// ----------------------------------------------------------------------------
// phase_field_driving_force_unit: top level of the driving force unit
// Computes phi*(1-phi)*(phi-1/2+m), m = alpha*atan(gamma*(t_e-T))/pi.
//
//   Channel    Role    Payload
//   point_in   sink    phase_value, temperature
//   force_out  source  driving_force
//   cfg        sink    index, data
//
// One point is taken per cycle unless the output stalls; the path runs through the
// set-up stages, the one-stage-per-iteration CORDIC and the product stages.
// Reset clears the valid bits and loads the register defaults.
// All stages advance together whenever the output stage is empty or taken;
// a stalled output holds every stage.
// ----------------------------------------------------------------------------
module phase_field_driving_force_unit #(
  parameter int ATAN_STAGES = 20
) (
  input  logic         clk,
  input  logic         rst,
  pfdf_point_if.sink   point_in,
  pfdf_force_if.source force_out,
  pfdf_cfg_if.sink     cfg
);

  logic [pfdf_pkg::ALPHA_W-1:0]        coupling;
  logic [pfdf_pkg::GAMMA_W-1:0]        gain;
  logic signed [pfdf_pkg::TEMP_W-1:0]  eq_temp;
  logic                                en;

  logic                                 f_valid;
  logic [pfdf_pkg::VEC_W-1:0]           f_x, f_y;
  pfdf_pkg::side_t                      f_side;
  logic                                 c_valid;
  logic signed [pfdf_pkg::CORDIC_W-1:0] c_z;
  pfdf_pkg::side_t                      c_side;

  assign en             = !force_out.valid || force_out.ready;
  assign point_in.ready = en;
  assign cfg.ready      = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coupling <= pfdf_pkg::RESET_COUPLING;
      gain     <= pfdf_pkg::RESET_GAIN;
      eq_temp  <= pfdf_pkg::RESET_EQ_TEMP;
    end else if (cfg.valid) begin
      unique case (pfdf_pkg::cfg_index_t'(cfg.index))
        pfdf_pkg::CFG_COUPLING: coupling <= cfg.data[pfdf_pkg::ALPHA_W-1:0];
        pfdf_pkg::CFG_GAIN:     gain     <= cfg.data;
        pfdf_pkg::CFG_EQ_TEMP:  eq_temp  <= cfg.data;
        default: ;
      endcase
    end
  end

  pfdf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (point_in.valid),
    .phase_value (point_in.phase_value),
    .temperature (point_in.temperature),
    .gain        (gain),
    .eq_temp     (eq_temp),
    .out_valid   (f_valid),
    .x_out       (f_x),
    .y_out       (f_y),
    .side_out    (f_side)
  );

  pfdf_cordic #(
    .ATAN_STAGES (ATAN_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .x_in      (f_x),
    .y_in      (f_y),
    .side_in   (f_side),
    .out_valid (c_valid),
    .z_out     (c_z),
    .side_out  (c_side)
  );

  pfdf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (c_valid),
    .z_in          (c_z),
    .side_in       (c_side),
    .alpha         (coupling),
    .out_valid     (force_out.valid),
    .driving_force (force_out.driving_force)
  );

endmodule
